// ===== rtl/stdc_pkg.sv =====
// Shared constants, types and helper functions of the sorted triple degree counter.
package stdc_pkg;

  // Width of every key and count field on the ports.
  localparam int unsigned FieldWidth  = 32;
  // Significant key bits and counter width of the design.
  localparam int unsigned KeyWidth    = 32;
  localparam int unsigned CountWidth  = 32;
  localparam int unsigned KeyCmpWidth = (KeyWidth < FieldWidth) ? KeyWidth : FieldWidth;

  // Result queue geometry.
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
  localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);

  // Result kinds.
  localparam logic KindGroup = 1'b0;
  localparam logic KindRun   = 1'b1;

  typedef logic [KeyCmpWidth-1:0] key_t;
  typedef logic [CountWidth-1:0]  count_t;

  typedef struct packed {
    logic                  kind;
    logic [FieldWidth-1:0] group_degree;
    logic [FieldWidth-1:0] run_degree;
    logic [FieldWidth-1:0] distinct_second;
    logic                  last_result;
  } res_t;

  // Words that one accepted triple pushes into the result queue, in order.
  typedef struct packed {
    logic [1:0] num;
    res_t       first;
    res_t       second;
  } push_t;

  function automatic logic [FieldWidth-1:0] count_to_field(input count_t c);
    logic [63:0] wide;
    wide = 64'(c);
    return wide[FieldWidth-1:0];
  endfunction

  function automatic count_t sat_inc(input count_t c);
    return (c == '1) ? c : c + count_t'(1);
  endfunction

endpackage

// ===== rtl/sorted_triple_degree_counter_unit.sv =====
// Top level of the sorted triple degree counter.
// Takes one sorted (first, second, third) key triple per cycle and reports, per
// first-key group, the distinct triple count, the length of each run of equal
// second keys and the number of distinct second keys. A triple makes zero, one
// or two result words; they enter a four-word result queue in the same cycle the
// triple is accepted and can leave it on the next cycle. The input is ready
// whenever the queue has room for two words, so the block sustains one triple
// per clock as long as the output drains at least as many words as arrive;
// with a stalled output, in_ready drops once three or four words are waiting.
module sorted_triple_degree_counter_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [stdc_pkg::FieldWidth-1:0] first_key_i,
  input  logic [stdc_pkg::FieldWidth-1:0] second_key_i,
  input  logic [stdc_pkg::FieldWidth-1:0] third_key_i,
  input  logic                            end_of_stream_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            kind_o,
  output logic [stdc_pkg::FieldWidth-1:0] group_degree_o,
  output logic [stdc_pkg::FieldWidth-1:0] run_degree_o,
  output logic [stdc_pkg::FieldWidth-1:0] distinct_second_o,
  output logic                            last_result_o
);
  import stdc_pkg::*;

  logic  accept;
  push_t push;
  res_t  head;

  assign accept = in_valid_i && in_ready_o;

  stdc_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .first_key_i    (first_key_i),
    .second_key_i   (second_key_i),
    .third_key_i    (third_key_i),
    .end_of_stream_i(end_of_stream_i),
    .push_o         (push)
  );

  stdc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (out_valid_o && out_ready_i),
    .room_o (in_ready_o),
    .valid_o(out_valid_o),
    .data_o (head)
  );

  assign kind_o            = head.kind;
  assign group_degree_o    = head.group_degree;
  assign run_degree_o      = head.run_degree;
  assign distinct_second_o = head.distinct_second;
  assign last_result_o     = head.last_result;

endmodule

// ===== rtl/stdc_core.sv =====
// Per-triple state update and result word generation.
module stdc_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic [stdc_pkg::FieldWidth-1:0]     first_key_i,
  input  logic [stdc_pkg::FieldWidth-1:0]     second_key_i,
  input  logic [stdc_pkg::FieldWidth-1:0]     third_key_i,
  input  logic                                end_of_stream_i,
  output stdc_pkg::push_t                     push_o
);
  import stdc_pkg::*;

  logic   have_q, have_d;
  key_t   prev_first_q, prev_first_d;
  key_t   prev_second_q, prev_second_d;
  key_t   prev_third_q, prev_third_d;
  count_t group_q, group_d;
  count_t run_q, run_d;
  count_t distinct_q, distinct_d;

  key_t   key_a, key_b, key_c;
  logic   same_first, same_second, is_dup;
  logic   trig_v;
  res_t   trig_res, flush_res;
  count_t upd_group, upd_run, upd_distinct;

  assign key_a = first_key_i[KeyCmpWidth-1:0];
  assign key_b = second_key_i[KeyCmpWidth-1:0];
  assign key_c = third_key_i[KeyCmpWidth-1:0];

  assign same_first  = (key_a == prev_first_q);
  assign same_second = (key_b == prev_second_q);
  assign is_dup      = have_q && same_first && same_second && (key_c == prev_third_q);

  always_comb begin
    have_d        = have_q;
    prev_first_d  = prev_first_q;
    prev_second_d = prev_second_q;
    prev_third_d  = prev_third_q;
    upd_group     = group_q;
    upd_run       = run_q;
    upd_distinct  = distinct_q;
    trig_v        = 1'b0;
    trig_res      = '0;

    if (!have_q || !same_first) begin
      // A new first key closes the open group (if any) and opens another.
      if (have_q) begin
        trig_v                   = 1'b1;
        trig_res.kind            = KindGroup;
        trig_res.group_degree    = count_to_field(group_q);
        trig_res.run_degree      = count_to_field(run_q);
        trig_res.distinct_second = count_to_field(distinct_q);
      end
      have_d        = 1'b1;
      prev_first_d  = key_a;
      prev_second_d = key_b;
      prev_third_d  = key_c;
      upd_group     = count_t'(1);
      upd_run       = count_t'(1);
      upd_distinct  = count_t'(1);
    end else if (!is_dup) begin
      upd_group = sat_inc(group_q);
      if (!same_second) begin
        trig_v              = 1'b1;
        trig_res.kind       = KindRun;
        trig_res.run_degree = count_to_field(run_q);
        upd_distinct        = sat_inc(distinct_q);
        upd_run             = count_t'(1);
      end else begin
        upd_run = sat_inc(run_q);
      end
      prev_second_d = key_b;
      prev_third_d  = key_c;
    end
    trig_res.last_result = !end_of_stream_i;

    group_d    = upd_group;
    run_d      = upd_run;
    distinct_d = upd_distinct;

    flush_res.kind            = KindGroup;
    flush_res.group_degree    = count_to_field(upd_group);
    flush_res.run_degree      = count_to_field(upd_run);
    flush_res.distinct_second = count_to_field(upd_distinct);
    flush_res.last_result     = 1'b1;

    // The end-of-stream flush returns everything to the reset state.
    if (end_of_stream_i) begin
      have_d        = 1'b0;
      prev_first_d  = '0;
      prev_second_d = '0;
      prev_third_d  = '0;
      group_d       = '0;
      run_d         = '0;
      distinct_d    = '0;
    end

    push_o.num    = accept_i ? ({1'b0, trig_v} + {1'b0, end_of_stream_i}) : 2'd0;
    push_o.first  = trig_v ? trig_res : flush_res;
    push_o.second = flush_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q        <= 1'b0;
      prev_first_q  <= '0;
      prev_second_q <= '0;
      prev_third_q  <= '0;
      group_q       <= '0;
      run_q         <= '0;
      distinct_q    <= '0;
    end else if (accept_i) begin
      have_q        <= have_d;
      prev_first_q  <= prev_first_d;
      prev_second_q <= prev_second_d;
      prev_third_q  <= prev_third_d;
      group_q       <= group_d;
      run_q         <= run_d;
      distinct_q    <= distinct_d;
    end
  end

endmodule

// ===== rtl/stdc_queue.sv =====
// Small result queue that takes up to two words per cycle and hands out one.
module stdc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  stdc_pkg::push_t push_i,
  input  logic            pop_i,
  output logic            room_o,
  output logic            valid_o,
  output stdc_pkg::res_t  data_o
);
  import stdc_pkg::*;

  res_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic [QueuePtrW-1:0] wr_ptr_nxt;

  assign wr_ptr_nxt = wr_ptr_q + QueuePtrW'(1);
  assign valid_o    = (cnt_q != '0);
  assign data_o     = mem_q[rd_ptr_q];
  // Room for the largest burst one triple can cause.
  assign room_o     = (cnt_q <= QueueCntW'(QueueDepth - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + QueuePtrW'(push_i.num);
    rd_ptr_d = rd_ptr_q + QueuePtrW'(pop_i);
    cnt_d    = cnt_q + QueueCntW'(push_i.num) - QueueCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push_i.second;
    end
  end

endmodule

// ===== rtl/stdc_checker.sv =====
// Port-level checks of the sorted triple degree counter and their bind.
module stdc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic [stdc_pkg::FieldWidth-1:0] first_key_i,
  input logic [stdc_pkg::FieldWidth-1:0] second_key_i,
  input logic [stdc_pkg::FieldWidth-1:0] third_key_i,
  input logic                            end_of_stream_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            kind_o,
  input logic [stdc_pkg::FieldWidth-1:0] group_degree_o,
  input logic [stdc_pkg::FieldWidth-1:0] run_degree_o,
  input logic [stdc_pkg::FieldWidth-1:0] distinct_second_o,
  input logic                            last_result_o
);
  import stdc_pkg::*;

  logic [3*FieldWidth+1:0] in_word;
  assign in_word = {first_key_i, second_key_i, third_key_i, end_of_stream_i, in_valid_i};

  // A waiting result word holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
      $stable(group_degree_o) && $stable(run_degree_o) &&
      $stable(distinct_second_o) && $stable(last_result_o))
    else $error("result word changed while stalled");

  // Run-closed words carry only the run count.
  a_run_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KindRun) |->
      group_degree_o == '0 && distinct_second_o == '0 && run_degree_o != '0)
    else $error("run-closed word carries group counts");

  // A closed group always holds at least one triple in one run.
  a_group_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KindGroup) |->
      group_degree_o != '0 && run_degree_o != '0 && distinct_second_o != '0)
    else $error("group-closed word with a zero count");

  // Runs and distinct second keys never exceed the triples of their group.
  a_group_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KindGroup) |->
      run_degree_o <= group_degree_o && distinct_second_o <= group_degree_o)
    else $error("group counts out of order");

  logic unused_in;
  assign unused_in = ^in_word ^ in_ready_o;

endmodule

bind sorted_triple_degree_counter_unit stdc_checker u_stdc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .first_key_i      (first_key_i),
  .second_key_i     (second_key_i),
  .third_key_i      (third_key_i),
  .end_of_stream_i  (end_of_stream_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .kind_o           (kind_o),
  .group_degree_o   (group_degree_o),
  .run_degree_o     (run_degree_o),
  .distinct_second_o(distinct_second_o),
  .last_result_o    (last_result_o)
);

// ===== bench/tb_sorted_triple_degree_counter_unit.sv =====
// Self-checking testbench for the sorted triple degree counter unit.
`timescale 1ns / 100ps

module tb_sorted_triple_degree_counter_unit;
  import stdc_pkg::*;

  localparam int unsigned RandomTriples = 760;
  localparam int unsigned CalmTail      = 150;
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned DirRows       = 22;

  typedef logic [FieldWidth-1:0] field_t;

  // One input word, with an optional typed-in flush result for the directed rows.
  typedef struct packed {
    field_t first;
    field_t second;
    field_t third;
    logic   eos;
    logic   typed;
    field_t t_group;
    field_t t_run;
    field_t t_distinct;
  } triple_word_t;

  localparam field_t Ones = '1;

  // Directed rows; every typed expectation is a single flush with last set.
  localparam triple_word_t DirTable [DirRows] = '{
    '{32'd0, 32'd0, 32'd0, 1'b1, 1'b1, 32'd1, 32'd1, 32'd1},
    '{Ones,  Ones,  Ones,  1'b1, 1'b1, 32'd1, 32'd1, 32'd1},
    '{32'd5, 32'd7, 32'd9, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{32'd5, 32'd7, 32'd9, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{32'd5, 32'd7, 32'd9, 1'b1, 1'b1, 32'd1, 32'd1, 32'd1},
    '{32'd10, 32'd1, 32'd1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{32'd10, 32'd1, 32'd2, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{32'd10, 32'd2, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{32'd10, 32'd2, 32'd5, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{32'd11, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{32'd11, 32'd3, 32'd3, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0},
    '{32'd12, 32'd4, 32'd4, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{32'd13, 32'd4, 32'd4, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0},
    '{32'd0,  Ones,  32'd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{32'd0,  Ones,  Ones,  1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{Ones,  32'd0,  Ones,  1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{Ones,  32'd0,  Ones,  1'b1, 1'b1, 32'd1, 32'd1, 32'd1},
    '{32'd1, 32'd2, 32'd3, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{32'd1, 32'd2, 32'd3, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{32'd1, 32'd2, 32'd4, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{32'd1, 32'd1, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{32'd0, 32'd0, 32'd0, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0}
  };

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid_i = 1'b0;
  logic   in_ready_o;
  field_t first_key_i = '0;
  field_t second_key_i = '0;
  field_t third_key_i = '0;
  logic   end_of_stream_i = 1'b0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  logic   kind_o;
  field_t group_degree_o;
  field_t run_degree_o;
  field_t distinct_second_o;
  logic   last_result_o;

  sorted_triple_degree_counter_unit i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .first_key_i       (first_key_i),
    .second_key_i      (second_key_i),
    .third_key_i       (third_key_i),
    .end_of_stream_i   (end_of_stream_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .kind_o            (kind_o),
    .group_degree_o    (group_degree_o),
    .run_degree_o      (run_degree_o),
    .distinct_second_o (distinct_second_o),
    .last_result_o     (last_result_o)
  );

  triple_word_t triple_q[$];
  res_t         degree_exp_q[$];
  res_t         fresh_q[$];

  // Predictor state.
  logic   open_seen;
  key_t   last_first, last_second, last_third;
  count_t grp_cnt, run_cnt, dist_cnt;

  int unsigned send_idx = 0;
  int unsigned in_gap = 0;
  int unsigned out_hold = 0;
  int unsigned mismatches = 0;
  int unsigned words_checked = 0;
  int unsigned group_words = 0;
  int unsigned run_words = 0;
  int unsigned cycles = 0;
  logic        calm;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input field_t got, input field_t want);
    if (got !== want) begin
      report_mismatch($sformatf("word %0d %s got %0h want %0h", words_checked, name, got,
                                want));
    end
  endtask

  task automatic push_triple(input field_t a, input field_t b, input field_t c,
                             input logic eos);
    triple_word_t w;
    w = '0;
    w.first  = a;
    w.second = b;
    w.third  = c;
    w.eos    = eos;
    triple_q.push_back(w);
  endtask

  function automatic res_t degree_word(input logic kind, input count_t g, input count_t r,
                                       input count_t d, input logic last);
    res_t x;
    x.kind            = kind;
    x.group_degree    = field_t'(g);
    x.run_degree      = field_t'(r);
    x.distinct_second = field_t'(d);
    x.last_result     = last;
    return x;
  endfunction

  function automatic count_t bump(input count_t c);
    return (&c) ? c : c + count_t'(1);
  endfunction

  task automatic open_degree_group(input key_t a, input key_t b, input key_t c);
    open_seen   = 1'b1;
    last_first  = a;
    last_second = b;
    last_third  = c;
    grp_cnt     = count_t'(1);
    run_cnt     = count_t'(1);
    dist_cnt    = count_t'(1);
  endtask

  task automatic clear_degrees();
    open_seen   = 1'b0;
    last_first  = '0;
    last_second = '0;
    last_third  = '0;
    grp_cnt     = '0;
    run_cnt     = '0;
    dist_cnt    = '0;
  endtask

  // Works out the result words that one accepted triple causes, into fresh_q.
  task automatic advance_degrees(input triple_word_t w);
    key_t a, b, c;
    res_t tail;
    a = key_t'(w.first);
    b = key_t'(w.second);
    c = key_t'(w.third);
    fresh_q.delete();
    if (!open_seen) begin
      open_degree_group(a, b, c);
    end else if (a == last_first && b == last_second && c == last_third) begin
      // A repeated triple leaves every count alone.
    end else if (a != last_first) begin
      fresh_q.push_back(degree_word(KindGroup, grp_cnt, run_cnt, dist_cnt, 1'b0));
      open_degree_group(a, b, c);
    end else begin
      grp_cnt = bump(grp_cnt);
      if (b != last_second) begin
        dist_cnt = bump(dist_cnt);
        fresh_q.push_back(degree_word(KindRun, '0, run_cnt, '0, 1'b0));
        run_cnt = count_t'(1);
      end else begin
        run_cnt = bump(run_cnt);
      end
      last_second = b;
      last_third  = c;
    end
    if (w.eos) begin
      fresh_q.push_back(degree_word(KindGroup, grp_cnt, run_cnt, dist_cnt, 1'b0));
      clear_degrees();
    end
    if (fresh_q.size() > 0) begin
      tail = fresh_q.pop_back();
      tail.last_result = 1'b1;
      fresh_q.push_back(tail);
    end
  endtask

  assign calm = (send_idx + CalmTail >= triple_q.size());

  // Input side: present triples in order, with random idle bursts between them.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_idx   = 0;
      in_gap     = 0;
      clear_degrees();
    end else begin
      if (in_valid_i && in_ready_o) begin
        advance_degrees(triple_q[send_idx]);
        if (triple_q[send_idx].typed) begin
          degree_exp_q.push_back(degree_word(KindGroup, triple_q[send_idx].t_group,
                                             triple_q[send_idx].t_run,
                                             triple_q[send_idx].t_distinct, 1'b1));
        end else begin
          foreach (fresh_q[k]) degree_exp_q.push_back(fresh_q[k]);
        end
        send_idx++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (in_gap > 0 && !calm) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (send_idx < triple_q.size()) begin
          in_gap = 0;
          in_valid_i      <= 1'b1;
          first_key_i     <= triple_q[send_idx].first;
          second_key_i    <= triple_q[send_idx].second;
          third_key_i     <= triple_q[send_idx].third;
          end_of_stream_i <= triple_q[send_idx].eos;
          if (!calm && $urandom_range(0, 6) == 0) in_gap = $urandom_range(1, 16);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output side: stall in random bursts, none in the calm tail.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_hold    = 0;
    end else if (out_hold > 0 && !calm) begin
      out_hold--;
      out_ready_i <= 1'b0;
    end else begin
      out_hold = 0;
      out_ready_i <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) out_hold = $urandom_range(1, 16);
    end
  end

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (degree_exp_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind %0b run %0h", kind_o, run_degree_o));
      end else begin
        res_t want;
        want = degree_exp_q.pop_front();
        check_field("kind", field_t'(kind_o), field_t'(want.kind));
        check_field("group_degree", group_degree_o, want.group_degree);
        check_field("run_degree", run_degree_o, want.run_degree);
        check_field("distinct_second", distinct_second_o, want.distinct_second);
        check_field("last_result", field_t'(last_result_o), field_t'(want.last_result));
        if (want.kind == KindGroup) group_words++;
        else run_words++;
      end
      words_checked++;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d words outstanding", cycles,
               degree_exp_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int unsigned fresh_items;
    int unsigned n_groups, n_runs, run_len, n_noise;
    field_t      fk, sk, tk;
    logic        eos;

    foreach (DirTable[r]) triple_q.push_back(DirTable[r]);

    // Mostly well-formed sorted streams with random content, some noise between them.
    fresh_items = 0;
    while (fresh_items < RandomTriples) begin
      if ($urandom_range(0, 9) < 8) begin
        fk = $urandom;
        n_groups = $urandom_range(1, 6);
        for (int g = 0; g < n_groups; g++) begin
          fk = fk + $urandom_range(1, 3);
          sk = $urandom;
          tk = $urandom;
          n_runs = $urandom_range(1, 5);
          for (int rr = 0; rr < n_runs; rr++) begin
            sk = sk + $urandom_range(1, 4);
            run_len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 6);
            for (int k = 0; k < run_len; k++) begin
              tk = tk + $urandom_range(1, 5);
              eos = (g == n_groups - 1 && rr == n_runs - 1 && k == run_len - 1) &&
                    ($urandom_range(0, 3) != 0);
              fresh_items++;
              if (eos && $urandom_range(0, 3) == 0) begin
                // The flush rides on a repeat of the last triple.
                push_triple(fk, sk, tk, 1'b0);
                push_triple(fk, sk, tk, 1'b1);
              end else begin
                push_triple(fk, sk, tk, eos);
                if (!eos && $urandom_range(0, 9) == 0) push_triple(fk, sk, tk, 1'b0);
              end
            end
          end
        end
      end else begin
        n_noise = $urandom_range(1, 4);
        for (int k = 0; k < n_noise; k++) begin
          push_triple($urandom, $urandom, $urandom, $urandom_range(0, 7) == 0);
          fresh_items++;
        end
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (send_idx < triple_q.size() || degree_exp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d triples (%0d directed rows, the rest random sorted streams and noise).",
             triple_q.size(), DirRows);
    $display("Checked %0d result words: %0d group closes and %0d run closes.",
             words_checked, group_words, run_words);
    if (mismatches == 0 && degree_exp_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
